@@ rtl/core/dics_pkg.sv @@
// Package for the display start-up list sequencer.
// Item types, decoder phases, result kinds and list constants.
// No dependencies.
package dics_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned DelayWidth = 16;

   localparam logic [ByteWidth-1:0] ListMarker       = 8'hFF;
   localparam logic [ByteWidth-1:0] DelayScaleReset  = 8'd10;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_DELAY   = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   // The fourth code is unused and decodes as a command phase
   typedef enum logic [1:0] {
      PHASE_COMMAND = 2'd0,
      PHASE_COUNT   = 2'd1,
      PHASE_ARGS    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] list_byte;
      logic                 restart;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [ByteWidth-1:0]  out_byte;
      logic [DelayWidth-1:0] delay_ms;
      logic                  last_argument;
   } rsp_type;

   // Decoder verdict for one item
   typedef struct packed {
      logic    has_result;
      rsp_type result;
   } verdict_type;

endpackage

@@ rtl/core/dics_parser.sv @@
// List parser: record state and the per-item decision.
// Depends on dics_pkg.
module dics_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_fire,
   input  dics_pkg::req_type                  item,
   input  logic [dics_pkg::ByteWidth-1:0]     delay_scale,
   output dics_pkg::verdict_type              verdict
);

   dics_pkg::phase_type                 phase_ff, phase_in, phase_eff;
   logic [dics_pkg::ByteWidth-1:0]      held_ff, held_in;
   logic [dics_pkg::ByteWidth-1:0]      args_ff, args_in, args_eff, args_dec;
   logic                                finished_ff, finished_in, finished_eff;
   logic [dics_pkg::DelayWidth-1:0]     delay_product;

   // restart clears the record in progress before the byte is looked at
   assign phase_eff    = item.restart ? dics_pkg::PHASE_COMMAND : phase_ff;
   assign args_eff     = item.restart ? '0 : args_ff;
   assign finished_eff = finished_ff & ~item.restart;
   assign args_dec     = (args_eff != '0) ? args_eff - 1'b1 : '0;

   assign delay_product = {{(dics_pkg::DelayWidth-dics_pkg::ByteWidth){1'b0}}, item.list_byte}
                        * {{(dics_pkg::DelayWidth-dics_pkg::ByteWidth){1'b0}}, delay_scale};

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      args_in     = args_ff;
      finished_in = finished_ff;
      if (item_fire) begin
         phase_in    = phase_eff;
         args_in     = args_eff;
         finished_in = finished_eff;
         if (!finished_eff) begin
            unique case (phase_eff)
               dics_pkg::PHASE_COUNT: begin
                  if (held_ff == dics_pkg::ListMarker) begin
                     phase_in    = dics_pkg::PHASE_COMMAND;
                     finished_in = (item.list_byte == dics_pkg::ListMarker);
                  end else begin
                     args_in  = item.list_byte;
                     phase_in = (item.list_byte == '0) ? dics_pkg::PHASE_COMMAND
                                                       : dics_pkg::PHASE_ARGS;
                  end
               end
               dics_pkg::PHASE_ARGS: begin
                  args_in  = args_dec;
                  phase_in = (args_dec == '0) ? dics_pkg::PHASE_COMMAND
                                              : dics_pkg::PHASE_ARGS;
               end
               default: begin
                  held_in  = item.list_byte;
                  phase_in = dics_pkg::PHASE_COUNT;
               end
            endcase
         end
      end
   end

   always_comb begin
      verdict            = '0;
      if (!finished_eff) begin
         unique case (phase_eff)
            dics_pkg::PHASE_COUNT: begin
               if (held_ff == dics_pkg::ListMarker) begin
                  verdict.has_result = 1'b1;
                  if (item.list_byte == dics_pkg::ListMarker) begin
                     verdict.result.kind = dics_pkg::KIND_END;
                  end else begin
                     verdict.result.kind     = dics_pkg::KIND_DELAY;
                     verdict.result.delay_ms = delay_product;
                  end
               end
            end
            dics_pkg::PHASE_ARGS: begin
               verdict.has_result           = 1'b1;
               verdict.result.kind          = dics_pkg::KIND_DATA;
               verdict.result.out_byte      = item.list_byte;
               verdict.result.last_argument = (args_eff <= 8'd1);
            end
            default: begin
               if (item.list_byte != dics_pkg::ListMarker) begin
                  verdict.has_result      = 1'b1;
                  verdict.result.kind     = dics_pkg::KIND_COMMAND;
                  verdict.result.out_byte = item.list_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dics_pkg::PHASE_COMMAND;
         held_ff     <= '0;
         args_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         args_ff     <= args_in;
         finished_ff <= finished_in;
      end
   end

endmodule

@@ rtl/core/dics_out_reg.sv @@
// Result register on the rsp channel.
// Depends on dics_pkg.
module dics_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  dics_pkg::rsp_type load_item,
   output logic              load_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dics_pkg::rsp_type rsp_item
);

   logic              valid_ff, valid_in;
   dics_pkg::rsp_type item_ff, item_in;

   assign load_free = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load_free) begin
         valid_in = load_valid;
         item_in  = load_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ rtl/core/display_init_command_list_sequencer_top.sv @@
// Top level of the display start-up list sequencer.
// Depends on dics_pkg, dics_parser and dics_out_reg.
//
// Usage:
//   req channel: one list byte per item with a restart flag; restart starts a
//   new list and the byte is then a command byte.
//   rsp channel: command, data (last argument flagged), delay request with
//   the pause in ms, or end of list. Items that give nothing (argument
//   counts, the first marker of a pause record, bytes after the end) drop
//   out quietly.
//   csr port: a write sets delay_scale (ms per pause unit, reset 10); write
//   only while no item is in flight.
// Timing: one item per cycle sustained while rsp_stall is low. An item is
//   held in the input register, decoded there, and its result is then held
//   in the result register. Rate is set by the record decode and the 8x8
//   delay multiply between the two registers.
// Reset (synchronous): both registers empty, parser expects a command byte.
// Stall: rsp_stall holds the result register; the input register then
//   stalls req once it holds an item, so nothing is dropped.
module display_init_command_list_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dics_pkg::req_type               req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dics_pkg::rsp_type               rsp_item,
   input  logic                            csr_wr_en,
   input  logic [dics_pkg::ByteWidth-1:0]  csr_wr_data
);

   logic                           in_valid_ff, in_valid_in;
   dics_pkg::req_type              in_item_ff, in_item_in;
   logic [dics_pkg::ByteWidth-1:0] scale_ff, scale_in;
   logic                           load_free;
   logic                           advance;
   dics_pkg::verdict_type          verdict;

   assign advance   = in_valid_ff & load_free;
   assign req_stall = in_valid_ff & ~load_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   assign scale_in = csr_wr_en ? csr_wr_data : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         scale_ff    <= dics_pkg::DelayScaleReset;
      end else begin
         in_valid_ff <= in_valid_in;
         scale_ff    <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   dics_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (advance),
      .item        (in_item_ff),
      .delay_scale (scale_ff),
      .verdict     (verdict)
   );

   dics_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (advance & verdict.has_result),
      .load_item  (verdict.result),
      .load_free  (load_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // req is only held back by a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("req stalled without downstream back-pressure");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.kind != dics_pkg::KIND_DELAY) |-> (rsp_item.delay_ms == '0))
      else $error("delay_ms set on a non-delay item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.kind != dics_pkg::KIND_DATA) |-> !rsp_item.last_argument)
      else $error("last_argument set on a non-data item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.kind == dics_pkg::KIND_DELAY ||
                     rsp_item.kind == dics_pkg::KIND_END)) |-> (rsp_item.out_byte == '0))
      else $error("out_byte set on a delay or end item");

endmodule

@@ sim/dics_list_checker.sv @@
`timescale 1ns / 100ps
// Checker for the display start-up list sequencer: watches req, rsp and csr,
// decodes the list itself and compares every rsp item in order.
// Depends on dics_pkg.
module dics_list_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  dics_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  dics_pkg::rsp_type               rsp_item,
   input  logic                            csr_wr_en,
   input  logic [dics_pkg::ByteWidth-1:0]  csr_wr_data,
   output int                              mismatches,
   output int                              ops_pending,
   output int                              results_checked
);

   dics_pkg::rsp_type panel_ops_due[$];

   dics_pkg::phase_type            phase;
   logic [dics_pkg::ByteWidth-1:0] held_command;
   logic [dics_pkg::ByteWidth-1:0] args_left;
   logic [dics_pkg::ByteWidth-1:0] scale;
   logic                           list_done;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= 20) begin
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   // Advances the list decoder by one byte; returns 1 when the byte yields a panel op
   function automatic bit decode_list_byte(input dics_pkg::req_type it,
                                           output dics_pkg::rsp_type op);
      logic [dics_pkg::ByteWidth-1:0] b;
      b  = it.list_byte;
      op = '0;
      if (it.restart) begin
         list_done = 1'b0;
         phase     = dics_pkg::PHASE_COMMAND;
         args_left = '0;
      end
      if (list_done) return 1'b0;
      case (phase)
         dics_pkg::PHASE_COUNT: begin
            if (held_command == dics_pkg::ListMarker) begin
               phase = dics_pkg::PHASE_COMMAND;
               if (b == dics_pkg::ListMarker) begin
                  list_done = 1'b1;
                  op.kind   = dics_pkg::KIND_END;
               end else begin
                  op.kind     = dics_pkg::KIND_DELAY;
                  op.delay_ms = dics_pkg::DelayWidth'(b) * dics_pkg::DelayWidth'(scale);
               end
               return 1'b1;
            end
            args_left = b;
            phase     = (b == '0) ? dics_pkg::PHASE_COMMAND : dics_pkg::PHASE_ARGS;
            return 1'b0;
         end
         dics_pkg::PHASE_ARGS: begin
            op.kind          = dics_pkg::KIND_DATA;
            op.out_byte      = b;
            op.last_argument = (args_left <= 1);
            if (args_left != '0) args_left = args_left - 1'b1;
            if (args_left == '0) phase = dics_pkg::PHASE_COMMAND;
            return 1'b1;
         end
         default: begin
            // a marker here opens a pause record and gives nothing yet
            held_command = b;
            phase        = dics_pkg::PHASE_COUNT;
            if (b == dics_pkg::ListMarker) return 1'b0;
            op.kind     = dics_pkg::KIND_COMMAND;
            op.out_byte = b;
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      dics_pkg::rsp_type got_op;
      dics_pkg::rsp_type due_op;
      if (reset) begin
         phase        = dics_pkg::PHASE_COMMAND;
         held_command = '0;
         args_left    = '0;
         list_done    = 1'b0;
         scale        = dics_pkg::DelayScaleReset;
         panel_ops_due.delete();
      end else begin
         if (csr_wr_en) scale = csr_wr_data;
         // retire first so an op queued at this edge is never matched early
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (panel_ops_due.size() == 0) begin
               report_mismatch("unexpected item kind", 32'(rsp_item.kind), 0);
            end else begin
               due_op = panel_ops_due.pop_front();
               if (rsp_item.kind !== due_op.kind)
                  report_mismatch("kind", 32'(rsp_item.kind), 32'(due_op.kind));
               if (rsp_item.out_byte !== due_op.out_byte)
                  report_mismatch("out_byte", 32'(rsp_item.out_byte),
                                  32'(due_op.out_byte));
               if (rsp_item.delay_ms !== due_op.delay_ms)
                  report_mismatch("delay_ms", 32'(rsp_item.delay_ms),
                                  32'(due_op.delay_ms));
               if (rsp_item.last_argument !== due_op.last_argument)
                  report_mismatch("last_argument", 32'(rsp_item.last_argument),
                                  32'(due_op.last_argument));
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_list_byte(req_item, got_op)) panel_ops_due.push_back(got_op);
         end
      end
      ops_pending <= panel_ops_due.size();
   end

endmodule

@@ sim/tb_display_init_command_list_sequencer_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the display start-up list sequencer: drives list bytes,
// delay scale writes and rsp back-pressure, and gives the verdict.
// Depends on dics_pkg, dics_list_checker and the sequencer RTL.
module tb_display_init_command_list_sequencer_top;

   localparam int ItemsPerPhase = 330;
   localparam int HoldCycles    = 120;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   dics_pkg::req_type              req_item;
   logic                           rsp_valid;
   logic                           rsp_stall;
   dics_pkg::rsp_type              rsp_item;
   logic                           csr_wr_en;
   logic [dics_pkg::ByteWidth-1:0] csr_wr_data;

   int mismatches;
   int ops_pending;
   int results_checked;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_taken   = 0;
   int scales_used   = 0;
   bit hold_wanted   = 1'b0;
   bit hold_done     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   display_init_command_list_sequencer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dics_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .ops_pending     (ops_pending),
      .results_checked (results_checked)
   );

   // Offers one list byte and returns at the edge where it is taken
   task automatic offer_list_byte(input logic [dics_pkg::ByteWidth-1:0] b, input bit rs,
                                  input bit counted = 1'b1);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{list_byte: b, restart: rs};
      do @(posedge clock); while (req_stall);
      if (counted) bytes_taken++;
   endtask

   // Drains the block: every op seen, then time for items that give nothing
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (ops_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_delay_scale(input logic [dics_pkg::ByteWidth-1:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      scales_used++;
   endtask

   // One list: mostly well-formed records, some noise and cut-short records
   task automatic offer_random_list();
      int  records;
      int  pick;
      int  count;
      int  cut;
      bit  rs;
      bit  ended;
      records = $urandom_range(1, 6);
      rs      = 1'b1;
      ended   = 1'b0;
      for (int r = 0; r < records; r++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            offer_list_byte(8'($urandom_range(255)), rs | 1'($urandom_range(1)));
         end else if (pick < 30) begin
            offer_list_byte(dics_pkg::ListMarker, rs);
            offer_list_byte(8'($urandom_range(254)), 1'b0);
         end else begin
            if ($urandom_range(79) == 0) count = $urandom_range(5, 255);
            else count = $urandom_range(0, 4);
            cut = ($urandom_range(19) == 0) ? $urandom_range(0, count) : count;
            offer_list_byte(8'($urandom_range(254)), rs);
            offer_list_byte(8'(count), 1'b0);
            for (int a = 0; a < cut; a++) offer_list_byte(8'($urandom_range(255)), 1'b0);
            if (cut != count) break;
         end
         rs = 1'b0;
      end
      if ($urandom_range(9) != 0) begin
         offer_list_byte(dics_pkg::ListMarker, rs);
         offer_list_byte(dics_pkg::ListMarker, 1'b0);
         ended = 1'b1;
      end
      // bytes after the end marker are dropped by the block
      if (ended) begin
         repeat ($urandom_range(0, 2)) offer_list_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
   endtask

   // Receiver: random stall, plus one long hold-off counted here
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int target;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_item    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed list at the reset delay scale
      offer_list_byte(8'h00, 1'b0);
      offer_list_byte(8'h02, 1'b0);
      offer_list_byte(8'hAA, 1'b0);
      offer_list_byte(8'h55, 1'b0);
      offer_list_byte(8'h11, 1'b0);
      offer_list_byte(8'h00, 1'b0);     // no arguments
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'h00, 1'b0);     // zero pause
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'hFE, 1'b0);
      offer_list_byte(8'h2A, 1'b0);
      offer_list_byte(8'h01, 1'b0);
      offer_list_byte(8'h7F, 1'b0);
      offer_list_byte(8'h36, 1'b0);
      offer_list_byte(8'h03, 1'b0);
      offer_list_byte(8'h01, 1'b0);
      offer_list_byte(8'hB0, 1'b1);     // restart mid-record
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'h12, 1'b0, 1'b0);
      offer_list_byte(dics_pkg::ListMarker, 1'b0, 1'b0);
      offer_list_byte(dics_pkg::ListMarker, 1'b1);
      offer_list_byte(8'h05, 1'b0);

      write_delay_scale(8'd255);
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'hFE, 1'b0);
      write_delay_scale(8'd1);
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'h01, 1'b0);
      write_delay_scale(8'd0);
      offer_list_byte(dics_pkg::ListMarker, 1'b0);
      offer_list_byte(8'h80, 1'b0);

      for (int p = 0; p < 3; p++) begin
         write_delay_scale(p == 2 ? 8'd255 : 8'($urandom_range(1, 255)));
         send_idle_pct = (p == 0) ? 25 : (p == 1) ? 47 : 0;
         recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 25 : 0;
         if (p == 2) begin
            // fill the block while the receiver holds off
            hold_wanted = 1'b1;
            for (int i = 0; i < 25; i++) begin
               offer_list_byte(8'($urandom_range(254)), i == 0);
               offer_list_byte(8'h01, 1'b0);
               offer_list_byte(8'($urandom_range(255)), 1'b0);
            end
         end
         target = bytes_taken + ItemsPerPhase;
         while (bytes_taken < target) offer_random_list();
      end

      wait_quiet();
      $display("Covered %0d list items and %0d checked results over %0d delay scale writes,",
               bytes_taken, results_checked, scales_used);
      $display("under random sender and receiver idling and a %0d-cycle receiver hold-off.",
               HoldCycles);
      if (mismatches == 0) begin
         $display("display_init_command_list_sequencer_top regression: pass");
      end else begin
         $display("display_init_command_list_sequencer_top regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d panel ops still due.", ops_pending);
      $display("display_init_command_list_sequencer_top regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/dics_pkg.sv
rtl/core/dics_parser.sv
rtl/core/dics_out_reg.sv
rtl/core/display_init_command_list_sequencer_top.sv
sim/dics_list_checker.sv
sim/tb_display_init_command_list_sequencer_top.sv
